// ===== hdl/batch_norm_inference_channel_affine_top_defines.svh =====
// Assertion macros shared by the batch-norm block.
// No dependencies; included by the modules that assert.
`ifndef BATCH_NORM_INFERENCE_CHANNEL_AFFINE_TOP_DEFINES_SVH
`define BATCH_NORM_INFERENCE_CHANNEL_AFFINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define BN_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BN_ASSERT(lbl, clk, rst, prop)
`define BN_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hdl/bnica_pkg.sv =====
// Types and constants for the batch-norm block.
// No dependencies.
package bnica_pkg;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_NUM_CHANNELS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_EPSILON = 1'b1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [5:0]  param_channel;
    logic signed [15:0] gamma_value;
    logic signed [15:0] beta_value;
    logic signed [15:0] mean_value;
    logic [15:0] variance_value;
    logic signed [15:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [5:0]  result_channel;
    logic        pixel_last;
    logic        saturated;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [15:0] data;
  } cfg_word_t;
endpackage

// ===== hdl/bnica_if.sv =====
// Valid/ready channel interfaces for the batch-norm block.
// Depends on bnica_pkg.
interface bnica_in_if (input logic clk);
  logic valid;
  logic ready;
  bnica_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bnica_out_if (input logic clk);
  logic valid;
  logic ready;
  bnica_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bnica_cfg_if (input logic clk);
  logic valid;
  logic ready;
  bnica_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/batch_norm_inference_channel_affine_top.sv =====
// channel  dir  payload
// in_ch    in   operation, param_channel, gamma/beta/mean/variance, sample
// out_ch   out  result_value, result_channel, pixel_last, saturated
// cfg_ch   in   index (0 num_channels, 1 epsilon_q), data
// Samples: one word per cycle through queue pop with RAM read, multiply,
// round/saturate; a stalled output holds the pipeline and then the queue.
// Parameter loads: the input is held after the accept (17-step sqrt,
// 36-step divide, multiply, table write); a load waits for the queue and read stage.
// Reset (rst, sync) clears config, queue, FSM, channel counter and stage valids.
// Depends on bnica_pkg, bnica_if, bnica_front, bnica_queue, bnica_back.
module batch_norm_inference_channel_affine_top #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic clk,
  input  logic rst,
  bnica_in_if.sink in_ch,
  bnica_out_if.source out_ch,
  bnica_cfg_if.sink cfg_ch
);
  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  logic [6:0] num_channels;
  logic [15:0] epsilon_q;
  logic q_push, q_pop, q_full, q_empty;
  logic pipe_busy;
  bnica_pkg::in_word_t q_in, q_out;
  logic tab_we;
  logic [ChW-1:0] tab_addr;
  logic [63:0] tab_wdata;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= 7'd64;
      epsilon_q <= 16'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        bnica_pkg::REG_NUM_CHANNELS: num_channels <= cfg_ch.data.data[6:0];
        bnica_pkg::REG_EPSILON: epsilon_q <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  bnica_front #(.ChW(ChW), .MaxCh(MAX_CHANNELS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .epsilon_q(epsilon_q),
    .q_push(q_push), .q_data(q_in), .q_full(q_full), .q_empty(q_empty),
    .pipe_busy(pipe_busy),
    .tab_we(tab_we), .tab_addr(tab_addr), .tab_wdata(tab_wdata)
  );

  bnica_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  bnica_back #(.ChW(ChW), .MaxCh(MAX_CHANNELS)) u_back (
    .clk(clk), .rst(rst), .num_channels(num_channels), .q_empty(q_empty),
    .q_data(q_out), .q_pop(q_pop), .pipe_busy(pipe_busy), .tab_we(tab_we),
    .tab_addr(tab_addr), .tab_wdata(tab_wdata), .out_ch(out_ch)
  );
endmodule

// ===== hdl/bnica_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module bnica_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/bnica_queue.sv =====
// Two-entry FIFO between front and back parts.
// Depends on bnica_pkg.
module bnica_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  bnica_pkg::in_word_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output bnica_pkg::in_word_t pop_data
);
  bnica_pkg::in_word_t slots [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wptr] <= push_data;
  end

`include "batch_norm_inference_channel_affine_top_defines.svh"
  `BN_ASSERT(a_no_overflow, clk, rst, push |-> !full)
  `BN_ASSERT(a_no_underflow, clk, rst, pop |-> !empty)
  `BN_ASSERT(a_count_max, clk, rst, count != 2'd3)
endmodule

// ===== hdl/bnica_front.sv =====
// Front part: takes input words, pushes sample words to the queue and
// folds load words into scale/offset (iterative sqrt and divide).
// Depends on bnica_pkg.
module bnica_front #(
  parameter int unsigned ChW = 6,
  parameter int unsigned MaxCh = 64
) (
  input  logic clk,
  input  logic rst,
  bnica_in_if.sink in_ch,
  input  logic [15:0] epsilon_q,
  output logic q_push,
  output bnica_pkg::in_word_t q_data,
  input  logic q_full,
  input  logic q_empty,
  input  logic pipe_busy,
  output logic tab_we,
  output logic [ChW-1:0] tab_addr,
  output logic [63:0] tab_wdata
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQRT = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_WR   = 5'b10000
  } fstate_t;

  fstate_t state;
  logic [ChW-1:0] ch;
  logic ch_ok;
  logic signed [15:0] g, b, m;
  logic [33:0] rem;   // sqrt remainder
  logic [16:0] root;
  logic [33:0] rad;   // radicand shifted out two bits a step
  logic [4:0]  step;
  logic [35:0] dnum;  // dividend (magnitude<<20 + r/2)
  logic [35:0] quo;
  logic [36:0] drem;
  logic [5:0]  dstep;
  logic signed [31:0] sc;
  logic signed [48:0] prod;

  logic take;
  logic [16:0] d;
  logic [33:0] trial;
  logic [36:0] dtrial;
  logic [15:0] gmag;
  logic signed [36:0] qs;
  logic signed [31:0] sc_sat;
  logic signed [40:0] off;
  logic signed [48:0] prnd;

  // a load waits until no queued or in-read sample can see the table change
  assign in_ch.ready = (state == S_IDLE) &&
                       (in_ch.data.operation == bnica_pkg::OP_LOAD ?
                        (q_empty && !pipe_busy) : !q_full);
  assign take = in_ch.valid && in_ch.ready;
  assign q_push = take && in_ch.data.operation == bnica_pkg::OP_SAMPLE;
  assign q_data = in_ch.data;
  assign d = {1'b0, in_ch.data.variance_value} + {1'b0, epsilon_q};
  assign trial = {rem[31:0], rad[33:32]} - {15'd0, root, 2'b01};
  assign dtrial = {drem[35:0], dnum[35]} - {20'd0, root};
  assign gmag = g[15] ? 16'(-g) : 16'(g);
  assign qs = g[15] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sc_sat = (qs > 37'sd2147483647) ? 32'sh7fffffff :
                  (qs < -37'sd2147483648) ? 32'sh80000000 : 32'(qs);
  assign prnd = (prod + 49'sd128) >>> 8;
  assign off = 41'(b) * 41'sd256 - 41'(prnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (take && in_ch.data.operation == bnica_pkg::OP_LOAD) state <= S_SQRT;
        S_SQRT: if (step == 5'd17) state <= S_DIV;
        S_DIV:  if (dstep == 6'd35) state <= S_MUL;
        S_MUL:  state <= S_WR;
        S_WR:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
    case (state)
      S_IDLE: begin
        ch <= ChW'(in_ch.data.param_channel);
        ch_ok <= 32'(in_ch.data.param_channel) < MaxCh;
        g <= in_ch.data.gamma_value;
        b <= in_ch.data.beta_value;
        m <= in_ch.data.mean_value;
        rad <= {1'b0, d, 16'd0};
        rem <= '0;
        root <= '0;
        step <= '0;
      end
      S_SQRT: begin
        if (step != 5'd17) begin
          rad <= {rad[31:0], 2'b00};
          if (!trial[33]) begin
            rem <= trial;
            root <= {root[15:0], 1'b1};
          end else begin
            rem <= {rem[31:0], rad[33:32]};
            root <= {root[15:0], 1'b0};
          end
        end
        step <= step + 5'd1;
        dnum <= {gmag, 20'd0} + 36'(root >> 1);
        drem <= '0;
        quo <= '0;
        dstep <= '0;
      end
      S_DIV: begin
        dnum <= {dnum[34:0], 1'b0};
        if (!dtrial[36]) begin
          drem <= dtrial;
          quo <= {quo[34:0], 1'b1};
        end else begin
          drem <= {drem[35:0], dnum[35]};
          quo <= {quo[34:0], 1'b0};
        end
        dstep <= dstep + 6'd1;
      end
      S_MUL: begin
        if (root == 17'd0) begin
          sc <= g[15] ? 32'sh80000000 : (g == 16'sd0 ? 32'sd0 : 32'sh7fffffff);
          prod <= 49'(m) * 49'(g[15] ? 32'sh80000000 :
                  (g == 16'sd0 ? 32'sd0 : 32'sh7fffffff));
        end else begin
          sc <= sc_sat;
          prod <= 49'(m) * 49'(sc_sat);
        end
      end
      default: ;
    endcase
  end

  assign tab_we = state == S_WR && ch_ok;
  assign tab_addr = ch;
  assign tab_wdata = {sc, (off > 41'sd2147483647) ? 32'sh7fffffff :
                      (off < -41'sd2147483648) ? 32'sh80000000 : 32'(off)};

`include "batch_norm_inference_channel_affine_top_defines.svh"
  `BN_ASSERT(a_load_waits_queue, clk, rst, (take && !q_push) |-> (q_empty && !pipe_busy))
  `BN_ASSERT(a_busy_no_take, clk, rst, (state != S_IDLE) |-> !take)
  `BN_ASSERT(a_write_after_mul, clk, rst, tab_we |-> $past(state == S_MUL))
endmodule

// ===== hdl/bnica_back.sv =====
// Back part: reads folded scale/offset for the channel, applies the affine
// step, saturates and holds the result word. Depends on bnica_pkg, bnica_ram.
module bnica_back #(
  parameter int unsigned ChW = 6,
  parameter int unsigned MaxCh = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic [6:0] num_channels,
  input  logic q_empty,
  input  bnica_pkg::in_word_t q_data,
  output logic q_pop,
  output logic pipe_busy,
  input  logic tab_we,
  input  logic [ChW-1:0] tab_addr,
  input  logic [63:0] tab_wdata,
  bnica_out_if.source out_ch
);
  // stage 1: RAM read; stage 2: multiply; stage 3: round/saturate into output
  logic s1_v, s2_v, o_v;
  logic signed [15:0] s1_x;
  logic [5:0] s1_pos;
  logic [ChW-1:0] s1_ridx;
  logic s1_last;
  logic [63:0] rd;
  logic signed [47:0] s2_p;
  logic signed [31:0] s2_off;
  logic [5:0] s2_pos;
  logic s2_last;
  logic [6:0] pos;
  logic [6:0] nact;
  logic adv, s2_move, o_load, last;
  logic signed [49:0] acc, y;
  logic [ChW-1:0] ridx;
  bnica_pkg::out_word_t o_word;

  assign nact = (num_channels == 7'd0) ? 7'd1 :
                (32'(num_channels) > MaxCh) ? 7'(MaxCh) : num_channels;
  assign last = pos + 7'd1 >= nact;
  assign ridx = (32'(pos) < MaxCh) ? ChW'(pos) : '0;

  assign o_load = !o_v || out_ch.ready;
  assign s2_move = !s2_v || o_load;
  assign adv = !s1_v || s2_move;
  assign q_pop = adv && !q_empty;
  assign pipe_busy = s1_v;

  // a held stage-1 word keeps reading its own entry
  bnica_ram #(.Width(64), .Depth(MaxCh)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_addr), .wdata(tab_wdata),
    .raddr(adv ? ridx : s1_ridx), .rdata(rd)
  );

  assign acc = 50'(s2_p) + 50'(s2_off) * 50'sd256 + 50'sd32768;
  assign y = acc >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      o_v <= 1'b0;
      pos <= '0;
    end else begin
      if (adv) s1_v <= q_pop;
      if (s2_move) s2_v <= s1_v && adv ? s1_v : (s1_v && !adv ? 1'b0 : 1'b0);
      if (o_load) o_v <= s2_v;
      if (q_pop) pos <= last ? 7'd0 : pos + 7'd1;
    end
    if (q_pop) begin
      s1_x <= q_data.sample_value;
      s1_pos <= pos[5:0];
      s1_ridx <= ridx;
      s1_last <= last;
    end
    if (s2_move) begin
      s2_p <= 48'(s1_x) * 48'($signed(rd[63:32]));
      s2_off <= $signed(rd[31:0]);
      s2_pos <= s1_pos;
      s2_last <= s1_last;
    end
    if (o_load && s2_v) begin
      o_word.result_channel <= s2_pos;
      o_word.pixel_last <= s2_last;
      o_word.saturated <= (y > 50'sd32767) || (y < -50'sd32768);
      o_word.result_value <= (y > 50'sd32767) ? 16'sh7fff :
                             (y < -50'sd32768) ? 16'sh8000 : 16'(y);
    end
  end

  assign out_ch.valid = o_v;
  assign out_ch.data = o_word;

`include "batch_norm_inference_channel_affine_top_defines.svh"
  `BN_ASSERT(a_pos_range, clk, rst, pos < 7'(MaxCh))
  `BN_ASSERT(a_out_hold, clk, rst, (o_v && !out_ch.ready) |=> o_v)
  `BN_ASSERT(a_wrap_on_last, clk, rst, (q_pop && last) |=> pos == 7'd0)
endmodule

// ===== bench/batch_norm_inference_channel_affine_top_tb.sv =====
// Testbench for the batch-norm inference block: directed table, then random traffic.
// Predicts folded scale/offset and per-sample results; checks every output word.
// Depends on bnica_pkg, bnica_if and the block's RTL.
`timescale 1ns / 100ps

module batch_norm_inference_channel_affine_top_tb;

  localparam int NCH = 64;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  bnica_in_if  in_ch  (clk);
  bnica_out_if out_ch (clk);
  bnica_cfg_if cfg_ch (clk);

  batch_norm_inference_channel_affine_top #(.MAX_CHANNELS(NCH)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  // predictor state
  logic signed [31:0] scale_q [NCH];
  logic signed [31:0] offset_q [NCH];
  bit loaded [NCH];
  int unsigned chan_pos;
  logic [6:0] chan_count;
  logic [15:0] eps_q;

  bnica_pkg::out_word_t result_fifo[$];
  int errors = 0;
  longint cycles = 0;
  bit rx_stall_on = 1'b1;
  bit tx_gap_on = 1'b1;

  typedef struct {
    bnica_pkg::in_word_t w;
    bit known;
    bnica_pkg::out_word_t res;
  } row_t;
  row_t rows[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shr(longint v, int k);
    longint t;
    t = v + (longint'(1) << (k - 1));
    return t >>> k;  // arithmetic floor of (v + half) equals rounding halves up
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic fold_params(bnica_pkg::in_word_t w);
    longint g, b, m, sc, off;
    longint unsigned d, r, mag, q;
    g = longint'(w.gamma_value);
    b = longint'(w.beta_value);
    m = longint'(w.mean_value);
    d = longint'(w.variance_value) + longint'(eps_q);
    r = int_sqrt(d << 16);
    if (r == 0) begin
      sc = g > 0 ? 64'sd2147483647 : (g < 0 ? -64'sd2147483648 : 64'sd0);
    end else begin
      mag = longint'(g < 0 ? -g : g) << 20;
      q = (mag + r / 2) / r;
      sc = sat32(g < 0 ? -longint'(q) : longint'(q));
    end
    off = sat32(b * 256 - round_shr(m * sc, 8));
    scale_q[w.param_channel] = 32'(sc);
    offset_q[w.param_channel] = 32'(off);
    loaded[w.param_channel] = 1'b1;
  endtask

  function automatic bnica_pkg::out_word_t normalize_sample(bnica_pkg::in_word_t w);
    bnica_pkg::out_word_t o;
    int unsigned n;
    longint acc, y;
    n = chan_count == 0 ? 1 : (chan_count > NCH ? NCH : chan_count);
    acc = longint'(w.sample_value) * longint'(scale_q[chan_pos])
        + longint'(offset_q[chan_pos]) * 256;
    y = round_shr(acc, 16);
    o.saturated = 1'b0;
    if (y > 32767) begin y = 32767; o.saturated = 1'b1; end
    if (y < -32768) begin y = -32768; o.saturated = 1'b1; end
    o.result_value = y[15:0];
    o.result_channel = chan_pos[5:0];
    o.pixel_last = (chan_pos + 1 >= n);
    chan_pos = o.pixel_last ? 0 : chan_pos + 1;
    return o;
  endfunction

  function automatic int unsigned active_count();
    return chan_count == 0 ? 1 : (chan_count > NCH ? NCH : chan_count);
  endfunction

  // drive one word; update prediction at acceptance; valid stays up for the next word
  task automatic send_word(bnica_pkg::in_word_t w, bit known, bnica_pkg::out_word_t res);
    bnica_pkg::out_word_t p;
    if (tx_gap_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (w.operation == bnica_pkg::OP_LOAD) begin
      fold_params(w);
    end else begin
      p = normalize_sample(w);
      if (known && p !== res) begin
        $display("%0t: directed row disagrees with predictor exp=%h got=%h", $time, res, p);
        errors++;
      end
      result_fifo.push_back(p);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_fifo.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);  // a trailing load may still be folding
  endtask

  task automatic write_reg(logic [bnica_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_ch.data <= '{index: idx, data: val};
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == bnica_pkg::REG_NUM_CHANNELS) chan_count = val[6:0];
    else eps_q = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bnica_pkg::in_word_t rand_word(bit op);
    bnica_pkg::in_word_t w;
    w.operation = op;
    w.param_channel = 6'($urandom_range(0, NCH - 1));
    w.gamma_value = 16'($urandom);
    w.beta_value = 16'($urandom);
    w.mean_value = 16'($urandom);
    w.variance_value = 16'($urandom);
    w.sample_value = 16'($urandom);
    case ($urandom_range(0, 5))
      0: w.sample_value = 16'h7FFF;
      1: w.sample_value = 16'h8000;
      2: w.variance_value = 16'h0000;
      3: w.gamma_value = 16'h0100;
      default: ;
    endcase
    return w;
  endfunction

  // output side: random stall bursts, compare at posedge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bnica_pkg::out_word_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_fifo.size() == 0) begin
        $display("%0t: unexpected word exp=none got=%h", $time, out_ch.data);
        errors++;
      end else begin
        e = result_fifo.pop_front();
        if (out_ch.data.result_value !== e.result_value) begin
          $display("%0t: result_value exp=%h got=%h", $time, e.result_value,
                   out_ch.data.result_value);
          errors++;
        end
        if (out_ch.data.result_channel !== e.result_channel) begin
          $display("%0t: result_channel exp=%0d got=%0d", $time, e.result_channel,
                   out_ch.data.result_channel);
          errors++;
        end
        if (out_ch.data.pixel_last !== e.pixel_last) begin
          $display("%0t: pixel_last exp=%b got=%b", $time, e.pixel_last,
                   out_ch.data.pixel_last);
          errors++;
        end
        if (out_ch.data.saturated !== e.saturated) begin
          $display("%0t: saturated exp=%b got=%b", $time, e.saturated,
                   out_ch.data.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic row_t mk(bnica_pkg::in_word_t w, bit known, bnica_pkg::out_word_t r);
    row_t x;
    x.w = w;
    x.known = known;
    x.res = r;
    return x;
  endfunction

  function automatic bnica_pkg::in_word_t ld(logic [5:0] ch, logic [15:0] g,
                                              logic [15:0] b, logic [15:0] m,
                                              logic [15:0] v);
    bnica_pkg::in_word_t w;
    w = '0;
    w.operation = bnica_pkg::OP_LOAD;
    w.param_channel = ch;
    w.gamma_value = g;
    w.beta_value = b;
    w.mean_value = m;
    w.variance_value = v;
    return w;
  endfunction

  function automatic bnica_pkg::in_word_t smp(logic [15:0] x);
    bnica_pkg::in_word_t w;
    w = '0;
    w.operation = bnica_pkg::OP_SAMPLE;
    w.sample_value = x;
    w.param_channel = 6'h3F;
    w.gamma_value = 16'hFFFF;
    w.beta_value = 16'hFFFF;
    w.mean_value = 16'hFFFF;
    w.variance_value = 16'hFFFF;
    return w;
  endfunction

  initial begin
    bnica_pkg::in_word_t w;
    int unsigned n, k;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    chan_pos = 0;
    chan_count = 7'd64;
    eps_q = 16'd1;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: 4 channels, identity, zero denominator, extremes
    write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd4);
    write_reg(bnica_pkg::REG_EPSILON, 16'd0);
    // var 1.0 -> identity channel 0
    rows.push_back(mk(ld(6'd0, 16'h0100, 16'h0000, 16'h0000, 16'h0100), 0, '0));
    // zero denominator, positive gamma -> saturates
    rows.push_back(mk(ld(6'd1, 16'h0100, 16'h0000, 16'h0000, 16'h0000), 0, '0));
    // zero denominator, negative gamma; offset clips and cancels the scale
    rows.push_back(mk(ld(6'd2, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000), 0, '0));
    // zero denominator, zero gamma: output is beta
    rows.push_back(mk(ld(6'd3, 16'h0000, 16'h8000, 16'h8000, 16'h0000), 0, '0));
    rows.push_back(mk(smp(16'h1234), 1, '{16'h1234, 6'd0, 1'b0, 1'b0}));
    rows.push_back(mk(smp(16'h0100), 1, '{16'h7FFF, 6'd1, 1'b0, 1'b1}));
    rows.push_back(mk(smp(16'h0100), 1, '{16'h0000, 6'd2, 1'b0, 1'b0}));
    rows.push_back(mk(smp(16'h7FFF), 1, '{16'h8000, 6'd3, 1'b1, 1'b0}));
    rows.push_back(mk(smp(16'h8000), 1, '{16'h8000, 6'd0, 1'b0, 1'b0}));
    rows.push_back(mk(smp(16'h0000), 1, '{16'h0000, 6'd1, 1'b0, 1'b0}));
    rows.push_back(mk(ld(6'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF), 0, '0));
    rows.push_back(mk(ld(6'd1, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF), 0, '0));
    rows.push_back(mk(smp(16'h7FFF), 0, '0));
    rows.push_back(mk(smp(16'h8000), 0, '0));
    rows.push_back(mk(smp(16'h7FFF), 0, '0));
    rows.push_back(mk(smp(16'h8000), 0, '0));
    foreach (rows[i]) send_word(rows[i].w, rows[i].known, rows[i].res);
    drain();

    // channel count lowered mid-pixel: position is 2, count 1 wraps
    write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd1);
    send_word(smp(16'h0040), 0, '0);
    send_word(smp(16'hFFC0), 0, '0);
    drain();
    // count 0 acts as one channel, count above range acts as 64
    write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd0);
    send_word(smp(16'h0001), 0, '0);
    drain();

    // random phases over several settings; load all used channels first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd1);
          write_reg(bnica_pkg::REG_EPSILON, 16'hFFFF);
        end
        1: begin
          write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd3);
          write_reg(bnica_pkg::REG_EPSILON, 16'($urandom));
        end
        2: begin
          write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd64);
          write_reg(bnica_pkg::REG_EPSILON, 16'd0);
        end
        3: begin
          write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'd127);
          write_reg(bnica_pkg::REG_EPSILON, 16'd1);
        end
        4: begin
          write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'($urandom_range(2, 16)));
          write_reg(bnica_pkg::REG_EPSILON, 16'($urandom));
        end
        default: begin
          write_reg(bnica_pkg::REG_NUM_CHANNELS, 16'($urandom_range(1, 8)));
          write_reg(bnica_pkg::REG_EPSILON, 16'($urandom));
          rx_stall_on = 1'b0;
          tx_gap_on = 1'b0;
        end
      endcase
      n = active_count();
      for (int c = 0; c < n; c++) begin
        if (!loaded[c] || $urandom_range(0, 3) == 0) begin
          w = rand_word(bnica_pkg::OP_LOAD);
          w.param_channel = 6'(c);
          send_word(w, 0, '0);
        end
      end
      for (k = 0; k < 110; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          w = rand_word(bnica_pkg::OP_LOAD);
          w.param_channel = 6'($urandom_range(0, n - 1));
        end else begin
          w = rand_word(bnica_pkg::OP_SAMPLE);
          if (!loaded[chan_pos]) w.operation = bnica_pkg::OP_LOAD;
          w.param_channel = w.operation == bnica_pkg::OP_LOAD ? chan_pos[5:0]
                                                              : w.param_channel;
        end
        send_word(w, 0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bnica_pkg.sv
hdl/bnica_if.sv
hdl/bnica_ram.sv
hdl/bnica_queue.sv
hdl/bnica_front.sv
hdl/bnica_back.sv
hdl/batch_norm_inference_channel_affine_top.sv
bench/batch_norm_inference_channel_affine_top_tb.sv
